@@ rtl/modbus_rtu_read_register_master_macros.svh @@
// Assertion macros for the Modbus RTU read master top-level design file.
`ifndef MODBUS_RTU_READ_REGISTER_MASTER_MACROS_SVH
`define MODBUS_RTU_READ_REGISTER_MASTER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define MBRTU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define MBRTU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mbrtu_pkg.sv @@
// Shared types, constants and the CRC-16 byte update for the Modbus RTU read master.
package mbrtu_pkg;

  localparam int QUEUE_DEPTH        = 2;
  localparam int MIN_RESPONSE_BYTES = 7;
  localparam int STORE_DEPTH        = 5;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_TIMEOUT_TICKS = 1'b0;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
  localparam logic [7:0] QUANTITY_HI       = 8'h00;
  localparam logic [7:0] QUANTITY_LO       = 8'h01;
  localparam logic [7:0] BYTE_COUNT_ONE    = 8'h02;
  localparam logic [15:0] TICK_MAX         = 16'hFFFF;

  // Positions within the eight-byte request frame.
  localparam logic [2:0] FB_SLAVE  = 3'd0;
  localparam logic [2:0] FB_FUNC   = 3'd1;
  localparam logic [2:0] FB_REG_HI = 3'd2;
  localparam logic [2:0] FB_REG_LO = 3'd3;
  localparam logic [2:0] FB_QTY_HI = 3'd4;
  localparam logic [2:0] FB_QTY_LO = 3'd5;
  localparam logic [2:0] FB_CRC_LO = 3'd6;
  localparam logic [2:0] FB_CRC_HI = 3'd7;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_RX_BYTE = 2'd1,
    OP_TICK    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_HEADER = 2'd1,
    ST_BAD_COUNT  = 2'd2,
    ST_TIMEOUT    = 2'd3
  } status_t;

  typedef enum logic {
    KIND_TX     = 1'b0,
    KIND_REPORT = 1'b1
  } kind_t;

  // One unit of work for the back end: a frame to send or a report to give.
  typedef struct packed {
    logic        is_report;
    logic [7:0]  slave;
    logic [15:0] reg_addr;
    logic [15:0] value;
    status_t     status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  // Reflected CRC-16 over one byte, eight shift steps.
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/mbrtu_front.sv @@
// Front end: tracks the pending read, collects response bytes and queues frames and reports.
module mbrtu_front import mbrtu_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         accept,
  input  logic [1:0]   operation,
  input  logic [7:0]   slave_address,
  input  logic [15:0]  register_address,
  input  logic [7:0]   rx_byte,
  input  logic [15:0]  timeout_ticks,
  output logic         push,
  output cmd_t         cmd,
  output logic         pending
);

  logic [7:0]  expected_slave, expected_slave_next;
  logic [2:0]  rx_count, rx_count_next;
  logic [15:0] tick_count, tick_count_next;
  logic        pending_next;
  logic [7:0]  rx_store [STORE_DEPTH];
  logic [7:0]  rx_view [STORE_DEPTH];
  logic        store_we;
  logic [2:0]  rx_count_inc;
  logic [15:0] tick_inc;
  op_t         op;

  assign op = op_t'(operation);
  assign rx_count_inc = rx_count + 3'd1;
  assign tick_inc = (tick_count != TICK_MAX) ? tick_count + 16'd1 : tick_count;

  // The byte being written this cycle is visible to the header check.
  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      rx_view[i] = (store_we && rx_count == 3'(i)) ? rx_byte : rx_store[i];
    end
  end

  always_comb begin
    pending_next        = pending;
    expected_slave_next = expected_slave;
    rx_count_next       = rx_count;
    tick_count_next     = tick_count;
    store_we            = 1'b0;
    push                = 1'b0;
    cmd                 = '0;
    cmd.slave           = slave_address;
    cmd.reg_addr        = register_address;
    if (accept) begin
      case (op)
        OP_START: begin
          pending_next        = 1'b1;
          expected_slave_next = slave_address;
          rx_count_next       = '0;
          tick_count_next     = '0;
          push                = 1'b1;
        end
        OP_RX_BYTE: begin
          if (pending) begin
            store_we      = (rx_count < 3'(STORE_DEPTH));
            rx_count_next = rx_count_inc;
            if (rx_count_inc >= 3'(MIN_RESPONSE_BYTES)) begin
              pending_next  = 1'b0;
              rx_count_next = '0;
              push          = 1'b1;
              cmd.is_report = 1'b1;
              if (rx_view[0] != expected_slave || rx_view[1] != FUNC_READ_HOLDING) begin
                cmd.status = ST_BAD_HEADER;
              end else if (rx_view[2] != BYTE_COUNT_ONE) begin
                cmd.status = ST_BAD_COUNT;
              end else begin
                cmd.status = ST_OK;
                cmd.value  = {rx_view[3], rx_view[4]};
              end
            end
          end
        end
        OP_TICK: begin
          if (pending) begin
            tick_count_next = tick_inc;
            if (tick_inc >= timeout_ticks) begin
              pending_next  = 1'b0;
              rx_count_next = '0;
              push          = 1'b1;
              cmd.is_report = 1'b1;
              cmd.status    = ST_TIMEOUT;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending        <= 1'b0;
      expected_slave <= '0;
      rx_count       <= '0;
      tick_count     <= '0;
    end else begin
      pending        <= pending_next;
      expected_slave <= expected_slave_next;
      rx_count       <= rx_count_next;
      tick_count     <= tick_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      rx_store[rx_count] <= rx_byte;
    end
  end

endmodule

@@ rtl/mbrtu_cmd_fifo.sv @@
// Short command queue between the front end and the back end.
module mbrtu_cmd_fifo import mbrtu_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  cmd_t         push_cmd,
  input  logic         pop,
  output cmd_t         head,
  output fifo_status_t fstat
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  cmd_t            mem [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign fstat.full  = (count == CntW'(DEPTH));
  assign fstat.empty = (count == '0);
  assign head        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

@@ rtl/mbrtu_back.sv @@
// Back end: serializes request frames with a running CRC and delivers reports.
module mbrtu_back import mbrtu_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cmd_t         head,
  input  fifo_status_t fstat,
  output logic         pop,
  input  logic         out_ready,
  output logic         out_valid,
  output kind_t        out_kind,
  output logic [7:0]   out_tx_byte,
  output logic         out_last,
  output logic [15:0]  out_value,
  output status_t      out_status,
  output logic [2:0]   byte_idx
);

  logic [15:0] crc;
  logic        load;
  logic [7:0]  frame_byte;

  always_comb begin
    case (byte_idx)
      FB_SLAVE:  frame_byte = head.slave;
      FB_FUNC:   frame_byte = FUNC_READ_HOLDING;
      FB_REG_HI: frame_byte = head.reg_addr[15:8];
      FB_REG_LO: frame_byte = head.reg_addr[7:0];
      FB_QTY_HI: frame_byte = QUANTITY_HI;
      FB_QTY_LO: frame_byte = QUANTITY_LO;
      FB_CRC_LO: frame_byte = crc[7:0];
      FB_CRC_HI: frame_byte = crc[15:8];
      default:   frame_byte = '0;
    endcase
  end

  always_comb begin
    load = (!out_valid || out_ready) && !fstat.empty;
    pop  = load && (head.is_report || byte_idx == FB_CRC_HI);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      byte_idx  <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      byte_idx  <= head.is_report ? '0 : byte_idx + 3'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (head.is_report) begin
        out_kind    <= KIND_REPORT;
        out_tx_byte <= '0;
        out_last    <= 1'b0;
        out_value   <= head.value;
        out_status  <= head.status;
      end else begin
        out_kind    <= KIND_TX;
        out_tx_byte <= frame_byte;
        out_last    <= (byte_idx == FB_CRC_HI);
        out_value   <= '0;
        out_status  <= ST_OK;
        if (byte_idx < FB_CRC_LO) begin
          crc <= crc_update((byte_idx == FB_SLAVE) ? CRC_INIT : crc, frame_byte);
        end
      end
    end
  end

endmodule

@@ rtl/modbus_rtu_read_register_master.sv @@
// Top level of the Modbus RTU single holding register read master.
//
//   Channel   Direction  Handshake            Payload
//   apb       in/out     psel/penable/pready  paddr, pwdata, prdata (timeout_ticks)
//   in        in         in_valid/in_ready    operation, slave_address,
//                                             register_address, rx_byte
//   out       out        out_valid/out_ready  kind, tx_byte, last_byte,
//                                             read_value, status
//
// A start transaction produces eight output transactions, one per cycle while out_ready
// holds, from the back end frame serializer and its one-byte-per-cycle CRC update; a new
// start is taken while a frame is still serialized if the queue has room. A report is
// registered at the output once it reaches the queue head and the output is free.
// Reset is synchronous and clears all control state; there is no clearing pass.
// A stalled output holds its register, the command queue absorbs QUEUE_DEPTH
// entries, and in_ready falls only when that queue is full.
`include "modbus_rtu_read_register_master_macros.svh"

module modbus_rtu_read_register_master import mbrtu_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            operation,
  input  logic [7:0]            slave_address,
  input  logic [15:0]           register_address,
  input  logic [7:0]            rx_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  kind,
  output logic [7:0]            tx_byte,
  output logic                  last_byte,
  output logic [15:0]           read_value,
  output logic [1:0]            status
);

  logic [15:0]  timeout_ticks;
  logic         cfg_sel;
  logic         in_accept;
  logic         push;
  logic         pop;
  logic         pending;
  cmd_t         push_cmd;
  cmd_t         head;
  fifo_status_t fstat;
  kind_t        out_kind;
  status_t      out_status;
  logic [2:0]   byte_idx;

  // The timeout register sits at byte address zero; the word index is paddr[2].
  assign pready  = 1'b1;
  assign cfg_sel = (paddr[CFG_ADDR_W-1] == REG_TIMEOUT_TICKS);
  assign prdata  = cfg_sel ? {{(CFG_DATA_W - 16){1'b0}}, timeout_ticks} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      timeout_ticks <= pwdata[15:0];
    end
  end

  // The front end takes a new transaction whenever the queue has room, even while
  // a frame is still being serialized or a result waits at the output.
  assign in_ready  = !fstat.full;
  assign in_accept = in_valid && in_ready;

  mbrtu_front u_front (
    .clk              (clk),
    .rst              (rst),
    .accept           (in_accept),
    .operation        (operation),
    .slave_address    (slave_address),
    .register_address (register_address),
    .rx_byte          (rx_byte),
    .timeout_ticks    (timeout_ticks),
    .push             (push),
    .cmd              (push_cmd),
    .pending          (pending)
  );

  mbrtu_cmd_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .fstat    (fstat)
  );

  mbrtu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .fstat       (fstat),
    .pop         (pop),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_kind    (out_kind),
    .out_tx_byte (tx_byte),
    .out_last    (last_byte),
    .out_value   (read_value),
    .out_status  (out_status),
    .byte_idx    (byte_idx)
  );

  assign kind   = out_kind;
  assign status = out_status;

  // The queue must never be written while full.
  `MBRTU_ASSERT_NOW(a_no_overflow, push, !fstat.full, "command queue overflow")

  // A frame in progress always has its command still at the queue head.
  `MBRTU_ASSERT_NOW(a_frame_has_cmd, byte_idx != FB_SLAVE, !fstat.empty && !head.is_report,
    "frame serializer running without a frame command")

  // Queuing a report always ends the pending read.
  `MBRTU_ASSERT_NEXT(a_report_ends_read, push && push_cmd.is_report, !pending,
    "read still pending after its report was queued")

endmodule
